FILE: hdl/tracker_row_sequencer_unit_assert.svh
// assertion macros shared by the row sequencer modules
`ifndef TRACKER_ROW_SEQUENCER_UNIT_ASSERT_SVH
`define TRACKER_ROW_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define TRS_ASSERT_IMP(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("row sequencer assertion failed");

// next-cycle implication
`define TRS_ASSERT_NXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("row sequencer assertion failed");

`endif

FILE: hdl/trs_pkg.sv
// types, constants and tables of the tracker row sequencer
package trs_pkg;

    localparam int ROW_BYTES    = 12;
    localparam int MAX_ROWS_DEF = 1344;
    localparam int MEL_CH_DEF   = 6;
    localparam int MAX_WRITES   = 42;
    localparam int DRUM_COL     = 11;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [1:0] CFG_TPR   = 2'd0;
    localparam logic [1:0] CFG_ROWS  = 2'd1;
    localparam logic [1:0] CFG_CMUTE = 2'd2;
    localparam logic [1:0] CFG_DMUTE = 2'd3;

    localparam logic [1:0] WS_MEL   = 2'd0;
    localparam logic [1:0] WS_PATCH = 2'd1;
    localparam logic [1:0] WS_BD0   = 2'd2;
    localparam logic [1:0] WS_BD1   = 2'd3;

    localparam logic [3:0] PID_NONE   = 4'd0;
    localparam logic [3:0] PID_BASS   = 4'd1;
    localparam logic [3:0] PID_SNARE  = 4'd2;
    localparam logic [3:0] PID_SNARE2 = 4'd3;
    localparam logic [3:0] PID_HIHAT  = 4'd4;
    localparam logic [3:0] PID_HIOP   = 4'd5;
    localparam logic [3:0] PID_CRASH  = 4'd6;
    localparam logic [3:0] PID_TOM1   = 4'd7;
    localparam logic [3:0] PID_TOM2   = 4'd8;

    localparam logic [7:0] PATCH_SKIP = 8'h92;
    localparam logic [7:0] REG_RHYTHM = 8'hBD;

    typedef struct packed {
        logic       take;
        logic       rd_en;
        logic [3:0] ch;
        logic       cap_cmd;
        logic       cap_drum;
        logic       emit;
        logic [1:0] wsel;
        logic [1:0] sub;
        logic       seg;
        logic [3:0] idx;
    } trs_cmd_t;

    typedef struct packed {
        logic       play_start;
        logic       mel_act;
        logic       mel_full;
        logic [3:0] seg_len;
        logic       patch_skip;
        logic       out_free;
    } trs_sts_t;

    typedef struct packed {
        logic [3:0] pid0;
        logic [3:0] pid1;
        logic [4:0] bl;
    } drum_plan_t;

    localparam logic [7:0] REG_BASE [10] = '{8'h30, 8'h33, 8'h50, 8'h53, 8'h70,
                                             8'h73, 8'h90, 8'h93, 8'hA6, 8'hB6};
    localparam logic [7:0] V_SNARE  [10] = '{8'h04, 8'h0F, 8'h3F, 8'h02, 8'hF1,
                                             8'hF7, 8'hFF, 8'hF7, 8'h59, 8'h01};
    localparam logic [7:0] V_SNARE2 [10] = '{8'h04, 8'h0F, 8'h3F, 8'h02, 8'hF1,
                                             8'hF7, 8'hFF, 8'hF7, 8'h20, 8'h02};
    localparam logic [7:0] V_BASS   [10] = '{8'h01, 8'h01, 8'h00, 8'h00, 8'hCF,
                                             8'hCF, 8'h68, 8'h07, 8'hAB, 8'h09};
    localparam logic [7:0] V_HIHAT  [10] = '{8'h01, 8'h09, 8'h30, 8'h0A, 8'hF7,
                                             8'hF6, 8'h77, 8'h77, 8'hFF, 8'h11};
    localparam logic [7:0] V_HIOP   [10] = '{8'h00, 8'h0F, 8'h12, 8'h30, 8'hF1,
                                             8'hF6, 8'h24, 8'hF8, 8'h58, 8'h18};
    localparam logic [7:0] V_CRASH  [10] = '{8'h00, 8'h0F, 8'h00, 8'h30, 8'hF6,
                                             8'hF6, 8'h24, 8'hF8, 8'h58, 8'h13};
    localparam logic [7:0] V_TOM1   [10] = '{8'h01, 8'h03, 8'h00, 8'h00, 8'hF6,
                                             8'hF2, 8'h27, 8'h28, 8'h58, 8'h14};
    localparam logic [7:0] V_TOM2   [10] = '{8'h01, 8'h03, 8'h02, 8'h00, 8'hF6,
                                             8'hF2, 8'h25, 8'h28, 8'h58, 8'h11};

    function automatic logic [9:0] fnum(input logic [3:0] semi);
        case (semi)
            4'd0:    fnum = 10'h159;
            4'd1:    fnum = 10'h16D;
            4'd2:    fnum = 10'h183;
            4'd3:    fnum = 10'h19A;
            4'd4:    fnum = 10'h1B2;
            4'd5:    fnum = 10'h1CC;
            4'd6:    fnum = 10'h1E8;
            4'd7:    fnum = 10'h205;
            4'd8:    fnum = 10'h223;
            4'd9:    fnum = 10'h244;
            4'd10:   fnum = 10'h267;
            default: fnum = 10'h28B;
        endcase
    endfunction

    // note number 0..62 into octave and semitone
    function automatic logic [6:0] note_split(input logic [5:0] n);
        logic [2:0] oct;
        logic [5:0] rem;
        oct = 3'd0;
        for (int k = 1; k < 6; k++) begin
            if (n >= 6'(12 * k)) begin
                oct = 3'(k);
            end
        end
        rem = n - ({oct, 3'b000} + {1'b0, oct, 2'b00});
        note_split = {oct, rem[3:0]};
    endfunction

    function automatic drum_plan_t drum_plan(input logic [3:0] sel, input logic sys2);
        drum_plan_t p;
        p = '{pid0: PID_NONE, pid1: PID_NONE, bl: 5'h00};
        if (sys2) begin
            case (sel)
                4'd1:        p = '{pid0: PID_BASS, pid1: PID_CRASH, bl: 5'h11};
                4'd7:        p = '{pid0: PID_HIHAT, pid1: PID_NONE, bl: 5'h02};
                4'd11, 4'd12: p = '{pid0: PID_SNARE, pid1: PID_NONE, bl: 5'h08};
                default:     p = '{pid0: PID_NONE, pid1: PID_NONE, bl: 5'h00};
            endcase
        end else begin
            case (sel)
                4'd1:        p = '{pid0: PID_BASS, pid1: PID_NONE, bl: 5'h10};
                4'd2:        p = '{pid0: PID_SNARE, pid1: PID_NONE, bl: 5'h08};
                4'd3:        p = '{pid0: PID_BASS, pid1: PID_HIOP, bl: 5'h11};
                4'd4:        p = '{pid0: PID_TOM2, pid1: PID_NONE, bl: 5'h04};
                4'd5:        p = '{pid0: PID_BASS, pid1: PID_CRASH, bl: 5'h11};
                4'd7:        p = '{pid0: PID_SNARE2, pid1: PID_NONE, bl: 5'h08};
                4'd9:        p = '{pid0: PID_TOM1, pid1: PID_NONE, bl: 5'h04};
                4'd11, 4'd12: p = '{pid0: PID_SNARE, pid1: PID_NONE, bl: 5'h08};
                default:     p = '{pid0: PID_NONE, pid1: PID_NONE, bl: 5'h00};
            endcase
        end
        drum_plan = p;
    endfunction

    function automatic logic [3:0] patch_len(input logic [3:0] pid);
        case (pid)
            PID_NONE:  patch_len = 4'd0;
            PID_CRASH: patch_len = 4'd12;
            default:   patch_len = 4'd10;
        endcase
    endfunction

    // {register, value} of one patch step
    function automatic logic [15:0] patch_write(input logic [3:0] pid, input logic [3:0] idx);
        logic [3:0] i;
        logic [7:0] bank;
        logic [7:0] v;
        i = idx;
        if (pid == PID_CRASH) begin
            i = idx - 4'd2;
        end
        if (i > 4'd9) begin
            i = 4'd9;
        end
        case (pid)
            PID_SNARE, PID_SNARE2, PID_HIOP, PID_CRASH: bank = 8'd1;
            PID_HIHAT, PID_TOM1, PID_TOM2:              bank = 8'd2;
            default:                                    bank = 8'd0;
        endcase
        case (pid)
            PID_BASS:   v = V_BASS[i];
            PID_SNARE:  v = V_SNARE[i];
            PID_SNARE2: v = V_SNARE2[i];
            PID_HIHAT:  v = V_HIHAT[i];
            PID_HIOP:   v = V_HIOP[i];
            PID_CRASH:  v = V_CRASH[i];
            PID_TOM1:   v = V_TOM1[i];
            default:    v = V_TOM2[i];
        endcase
        if (pid == PID_CRASH && idx < 4'd2) begin
            patch_write = {(idx == 4'd0) ? 8'h32 : 8'h35, 8'h3F};
        end else begin
            patch_write = {REG_BASE[i] + bank, v};
        end
    endfunction

endpackage

FILE: hdl/trs_ram.sv
// generic single-port-write ram with registered read
module trs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: hdl/trs_ctrl.sv
// sequencing state machine for one played row
`include "tracker_row_sequencer_unit_assert.svh"
module trs_ctrl #(
    parameter int MELODIC_CHANNELS = trs_pkg::MEL_CH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  trs_pkg::trs_sts_t sts,
    output trs_pkg::trs_cmd_t cmd
);
    import trs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CAP   = 3'd2;
    localparam logic [2:0] S_MEL   = 3'd3;
    localparam logic [2:0] S_PATCH = 3'd4;
    localparam logic [2:0] S_BD0   = 3'd5;
    localparam logic [2:0] S_BD1   = 3'd6;
    localparam logic [3:0] DRUM_CH = 4'(MELODIC_CHANNELS);

    logic [2:0] state_reg, state_next;
    logic [3:0] ch_reg, ch_next;
    logic [1:0] sub_reg, sub_next;
    logic       seg_reg, seg_next;
    logic [3:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
            sub_reg   <= '0;
            seg_reg   <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            sub_reg   <= sub_next;
            seg_reg   <= seg_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        sub_next   = sub_reg;
        seg_next   = seg_reg;
        idx_next   = idx_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.ch     = ch_reg;
        cmd.sub    = sub_reg;
        cmd.seg    = seg_reg;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
                if (s_valid && sts.play_start) begin
                    ch_next    = '0;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = S_CAP;
            end
            S_CAP: begin
                if (ch_reg == DRUM_CH) begin
                    cmd.cap_drum = 1'b1;
                    seg_next     = 1'b0;
                    idx_next     = '0;
                    state_next   = S_PATCH;
                end else begin
                    cmd.cap_cmd = 1'b1;
                    sub_next    = '0;
                    state_next  = S_MEL;
                end
            end
            S_MEL: begin
                cmd.wsel = WS_MEL;
                if (!sts.mel_act) begin
                    ch_next    = ch_reg + 4'd1;
                    state_next = S_READ;
                end else if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    // note-off only, or the note-on pair done
                    if ((sub_reg == 2'd0 && !sts.mel_full) || sub_reg == 2'd2) begin
                        ch_next    = ch_reg + 4'd1;
                        state_next = S_READ;
                    end else begin
                        sub_next = sub_reg + 2'd1;
                    end
                end
            end
            S_PATCH: begin
                cmd.wsel = WS_PATCH;
                if (idx_reg >= sts.seg_len) begin
                    if (seg_reg) begin
                        state_next = S_BD0;
                    end else begin
                        seg_next = 1'b1;
                        idx_next = '0;
                    end
                end else if (sts.patch_skip) begin
                    idx_next = idx_reg + 4'd1;
                end else if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    idx_next = idx_reg + 4'd1;
                end
            end
            S_BD0: begin
                cmd.wsel = WS_BD0;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_BD1;
                end
            end
            S_BD1: begin
                cmd.wsel = WS_BD1;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `TRS_ASSERT_IMP(a_emit_free, aclk, aresetn, cmd.emit, sts.out_free)
    `TRS_ASSERT_NXT(a_row_done, aclk, aresetn, state_reg == S_BD1 && cmd.emit, state_reg == S_IDLE)
endmodule

FILE: hdl/trs_datapath.sv
// pattern store, playback state, write generation and output register
`include "tracker_row_sequencer_unit_assert.svh"
module trs_datapath #(
    parameter int MAX_ROWS         = trs_pkg::MAX_ROWS_DEF,
    parameter int MELODIC_CHANNELS = trs_pkg::MEL_CH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        s_req_type,
    input  logic [13:0]       s_load_address,
    input  logic [7:0]        s_load_data,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [10:0]       cfg_data,
    input  trs_pkg::trs_cmd_t cmd,
    output trs_pkg::trs_sts_t sts,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_reg_address,
    output logic [7:0]        m_reg_value,
    output logic              m_last_of_run,
    output logic              m_song_end
);
    import trs_pkg::*;

    localparam int         STORE_BYTES = MAX_ROWS * ROW_BYTES;
    localparam int         AW          = $clog2(STORE_BYTES);
    localparam logic [16:0] STORE_V    = 17'(STORE_BYTES);
    localparam logic [12:0] MAX_ROWS_V = 13'(MAX_ROWS);

    logic [8:0]  tpr_reg;
    logic [10:0] rows_reg;
    logic [8:0]  cmute_reg;
    logic [2:0]  dmute_reg;

    logic [10:0] row_index_reg;
    logic [8:0]  tick_reg;
    logic        finished_reg;
    logic [4:0]  prev_drum_reg;
    logic [10:0] scan_row_reg;
    logic [7:0]  scan_code_reg;
    logic [AW-1:0] base_reg;
    logic        end_reg;
    logic [5:0]  wr_cnt_reg;
    logic [7:0]  byte_reg;
    logic [3:0]  pid0_reg, pid1_reg;
    logic [7:0]  bd_first_reg, bd_second_reg;
    logic        m_valid_reg;
    logic [7:0]  m_addr_reg, m_val_reg;
    logic        m_last_reg, m_end_reg;

    // load address split: row by reciprocal of twelve, column by remainder
    logic [29:0] div_prod;
    logic [10:0] ld_row;
    logic [13:0] ld_col;
    logic        ld_in_range;
    logic        ld_en;
    logic [16:0] addr_ext;

    assign div_prod    = 30'(s_load_address) * 30'd43691;
    assign ld_row      = div_prod[29:19];
    assign ld_col      = s_load_address - (14'({ld_row, 3'b000}) + 14'({ld_row, 2'b00}));
    assign ld_in_range = {3'b000, s_load_address} < STORE_V;
    assign ld_en       = cmd.take && s_req_type == REQ_LOAD && ld_in_range;
    assign addr_ext    = {3'b000, s_load_address};

    logic        tick_take;
    logic        due;
    logic        beyond;
    logic [14:0] base_full;

    assign tick_take = cmd.take && s_req_type == REQ_TICK;
    assign due       = ({1'b0, tick_reg} + 10'd1) >= {1'b0, tpr_reg};
    assign beyond    = row_index_reg >= rows_reg || {2'b00, row_index_reg} >= MAX_ROWS_V;
    assign base_full = 15'({row_index_reg, 3'b000}) + 15'({row_index_reg, 2'b00});

    assign sts.play_start = tick_take && due && !finished_reg && !beyond;

    // pattern memory: melodic columns by channel, then the drum column
    logic [AW-1:0] rd_addr_sel;
    logic [7:0]    rd_data;

    assign rd_addr_sel = (cmd.ch >= 4'(MELODIC_CHANNELS)) ? base_reg + AW'(DRUM_COL)
                                                          : base_reg + AW'(cmd.ch);

    trs_ram #(
        .WIDTH(8),
        .DEPTH(STORE_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ld_en),
        .waddr (addr_ext[AW-1:0]),
        .wdata (s_load_data),
        .re    (cmd.rd_en),
        .raddr (rd_addr_sel),
        .rdata (rd_data)
    );

    // melodic command decode
    logic [6:0] split;
    logic [9:0] f;
    logic [2:0] oct;
    logic [3:0] ch_mask_idx;

    assign split       = note_split(6'(byte_reg - 8'd1));
    assign oct         = split[6:4];
    assign f           = fnum(split[3:0]);
    assign ch_mask_idx = (cmd.ch > 4'd8) ? 4'd8 : cmd.ch;

    assign sts.mel_act  = byte_reg != 8'd0 && byte_reg <= 8'd64 && !cmute_reg[ch_mask_idx];
    assign sts.mel_full = byte_reg < 8'd64;

    // drum decode on the captured drum byte
    logic       sys2;
    logic [7:0] dcode;
    drum_plan_t plan;
    logic [4:0] bl;
    logic [7:0] first;

    assign sys2  = scan_code_reg > 8'h0F;
    assign dcode = sys2 ? {4'h0, rd_data[7:4]} : rd_data;
    assign plan  = drum_plan(dcode[3:0], sys2);

    always_comb begin
        bl = plan.bl;
        if (dmute_reg[0]) begin
            bl = bl & ~5'h10;
        end
        if (dmute_reg[1]) begin
            bl = bl & ~5'h0A;
        end
        if (dmute_reg[2]) begin
            bl = bl & ~5'h05;
        end
        first = {3'b001, prev_drum_reg & (bl ^ 5'd31)};
    end

    logic [3:0]  cur_pid;
    logic [15:0] pw;

    assign cur_pid        = cmd.seg ? pid1_reg : pid0_reg;
    assign pw             = patch_write(cur_pid, cmd.idx);
    assign sts.seg_len    = patch_len(cur_pid);
    assign sts.patch_skip = pw[7:0] == PATCH_SKIP;
    assign sts.out_free   = !m_valid_reg || m_ready;

    // write selection
    logic [7:0] w_addr, w_val;
    always_comb begin
        case (cmd.wsel)
            WS_MEL: begin
                case (cmd.sub)
                    2'd0: begin
                        w_addr = 8'hB0 + {4'h0, cmd.ch};
                        w_val  = 8'h00;
                    end
                    2'd1: begin
                        w_addr = 8'hA0 + {4'h0, cmd.ch};
                        w_val  = f[7:0];
                    end
                    default: begin
                        w_addr = 8'hB0 + {4'h0, cmd.ch};
                        w_val  = 8'h20 | {3'b000, oct + 3'd2, 2'b00} | {6'h00, f[9:8]};
                    end
                endcase
            end
            WS_PATCH: begin
                w_addr = pw[15:8];
                w_val  = pw[7:0];
            end
            WS_BD0: begin
                w_addr = REG_RHYTHM;
                w_val  = bd_first_reg;
            end
            default: begin
                w_addr = REG_RHYTHM;
                w_val  = bd_second_reg;
            end
        endcase
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpr_reg   <= 9'd1;
            rows_reg  <= 11'd1;
            cmute_reg <= '0;
            dmute_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TPR:   tpr_reg   <= cfg_data[8:0];
                CFG_ROWS:  rows_reg  <= cfg_data;
                CFG_CMUTE: cmute_reg <= cfg_data[8:0];
                CFG_DMUTE: dmute_reg <= cfg_data[2:0];
                default:   tpr_reg   <= tpr_reg;
            endcase
        end
    end

    // playback and scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_index_reg <= '0;
            tick_reg      <= '0;
            finished_reg  <= 1'b0;
            prev_drum_reg <= '0;
            scan_row_reg  <= '0;
            scan_code_reg <= '0;
            wr_cnt_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (ld_en && ld_col == 14'(DRUM_COL)) begin
                if (s_load_data != 8'd0) begin
                    if (scan_code_reg == 8'd0 || ld_row >= scan_row_reg) begin
                        scan_row_reg  <= ld_row;
                        scan_code_reg <= s_load_data;
                    end
                end else if (scan_code_reg != 8'd0 && ld_row == scan_row_reg) begin
                    scan_code_reg <= 8'd0;
                end
            end
            if (cmd.take && s_req_type == REQ_RESTART) begin
                row_index_reg <= '0;
                tick_reg      <= '0;
                finished_reg  <= 1'b0;
                prev_drum_reg <= '0;
            end
            if (tick_take) begin
                if (due) begin
                    tick_reg <= '0;
                    if (!finished_reg) begin
                        if (beyond) begin
                            finished_reg <= 1'b1;
                        end else begin
                            row_index_reg <= row_index_reg + 11'd1;
                            wr_cnt_reg    <= '0;
                            if (row_index_reg + 11'd1 == rows_reg) begin
                                finished_reg <= 1'b1;
                            end
                        end
                    end
                end else begin
                    tick_reg <= tick_reg + 9'd1;
                end
            end
            if (cmd.cap_drum) begin
                prev_drum_reg <= bl;
            end
            if (cmd.emit && wr_cnt_reg < 6'(MAX_WRITES)) begin
                m_valid_reg <= 1'b1;
                wr_cnt_reg  <= wr_cnt_reg + 6'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (sts.play_start) begin
            base_reg <= AW'(base_full);
            end_reg  <= row_index_reg + 11'd1 == rows_reg;
        end
        if (cmd.cap_cmd) begin
            byte_reg <= rd_data;
        end
        if (cmd.cap_drum) begin
            pid0_reg      <= plan.pid0;
            pid1_reg      <= plan.pid1;
            bd_first_reg  <= first;
            bd_second_reg <= first | {3'b001, bl};
        end
        if (cmd.emit && wr_cnt_reg < 6'(MAX_WRITES)) begin
            m_addr_reg <= w_addr;
            m_val_reg  <= w_val;
            m_last_reg <= cmd.wsel == WS_BD1 || wr_cnt_reg == 6'(MAX_WRITES - 1);
            m_end_reg  <= end_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_reg_address = m_addr_reg;
    assign m_reg_value   = m_val_reg;
    assign m_last_of_run = m_last_reg;
    assign m_song_end    = m_end_reg;

    `TRS_ASSERT_IMP(a_cnt_cap, aclk, aresetn, 1'b1, wr_cnt_reg <= 6'(MAX_WRITES))
    `TRS_ASSERT_NXT(a_row_adv, aclk, aresetn, sts.play_start, row_index_reg == $past(row_index_reg) + 11'd1)
endmodule

FILE: hdl/tracker_row_sequencer_unit.sv
// loads, restarts and non-row ticks keep it idle; the next item can be taken the cycle after
// a played row reads and captures each melodic channel, with a key-off and for a note-on
// two more writes, then the drum byte, both patch segments and the two rhythm writes
// write rate is one per cycle unless m_ready stalls, bounded by the output reg and ram port
// reset (aresetn low, synchronous) clears playback, drum scan and config registers to their defaults
// the pattern store is not cleared; bytes must be loaded before they are played
module tracker_row_sequencer_unit #(
    parameter int MAX_ROWS         = trs_pkg::MAX_ROWS_DEF,
    parameter int MELODIC_CHANNELS = trs_pkg::MEL_CH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [13:0] s_load_address,
    input  logic [7:0]  s_load_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_reg_address,
    output logic [7:0]  m_reg_value,
    output logic        m_last_of_run,
    output logic        m_song_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import trs_pkg::*;

    trs_cmd_t cmd;
    trs_sts_t sts;

    assign cfg_ready = 1'b1;

    trs_ctrl #(
        .MELODIC_CHANNELS(MELODIC_CHANNELS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    trs_datapath #(
        .MAX_ROWS(MAX_ROWS),
        .MELODIC_CHANNELS(MELODIC_CHANNELS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_req_type     (s_req_type),
        .s_load_address (s_load_address),
        .s_load_data    (s_load_data),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_reg_address  (m_reg_address),
        .m_reg_value    (m_reg_value),
        .m_last_of_run  (m_last_of_run),
        .m_song_end     (m_song_end)
    );
endmodule

FILE: dv/tracker_row_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the tracker row sequencer with its own write predictor
module tracker_row_sequencer_unit_tb;
    import trs_pkg::*;

    localparam int STORE_BYTES = MAX_ROWS_DEF * ROW_BYTES;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [1:0]  req;
        logic [13:0] addr;
        logic [7:0]  data;
    } req_item_t;

    typedef struct packed {
        logic [7:0] address;
        logic [7:0] value;
        logic       last;
        logic       ends_song;
    } chip_write_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = '0;
    logic [13:0] s_load_address = '0;
    logic [7:0]  s_load_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_reg_address;
    logic [7:0]  m_reg_value;
    logic        m_last_of_run;
    logic        m_song_end;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;

    tracker_row_sequencer_unit uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [7:0]  pat_mem [STORE_BYTES];
    bit          pat_written [STORE_BYTES];
    int          play_row_idx, tick_cnt, prev_bits, scan_row, scan_code;
    bit          finished;
    int          tpr_cfg, rows_cfg, cmute_cfg, dmute_cfg;

    req_item_t   pending_reqs[$];
    chip_write_t expected_writes[$];
    chip_write_t row_writes[$];
    int          n_pushed, n_taken, cycles, errors;
    int          idle_pct, stall_pct;
    bit          s_took, running;

    logic [9:0] fnum_tab [12] = '{10'h159, 10'h16D, 10'h183, 10'h19A, 10'h1B2, 10'h1CC,
                                  10'h1E8, 10'h205, 10'h223, 10'h244, 10'h267, 10'h28B};

    task automatic add_write(input logic [7:0] a, input logic [7:0] v);
        if (row_writes.size() < MAX_WRITES) begin
            row_writes.push_back('{a, v, 1'b0, 1'b0});
        end
    endtask

    // bank 0 bass, 1 snare/mid, 2 hihat/tom
    task automatic add_patch(input int bank, input logic [7:0] vals [10]);
        for (int i = 0; i < 10; i++) begin
            if (vals[i] != PATCH_SKIP) add_write(REG_BASE[i] + 8'(bank), vals[i]);
        end
    endtask

    task automatic add_crash();
        add_write(8'h32, 8'h3F);
        add_write(8'h35, 8'h3F);
        add_patch(1, V_CRASH);
    endtask

    task automatic play_drums(input logic [7:0] data);
        bit         sys2;
        logic [3:0] sel;
        logic [4:0] bl;
        logic [7:0] first;
        sys2 = scan_code > 8'h0F;
        sel = sys2 ? data[7:4] : data[3:0];
        bl = '0;
        if (sys2) begin
            case (sel)
                4'd1: begin add_patch(0, V_BASS); add_crash(); bl = 5'h11; end
                4'd7: begin add_patch(2, V_HIHAT); bl = 5'h02; end
                4'd11, 4'd12: begin add_patch(1, V_SNARE); bl = 5'h08; end
                default: bl = 5'h00;
            endcase
        end else begin
            case (sel)
                4'd1: begin add_patch(0, V_BASS); bl = 5'h10; end
                4'd2: begin add_patch(1, V_SNARE); bl = 5'h08; end
                4'd3: begin add_patch(0, V_BASS); add_patch(1, V_HIOP); bl = 5'h11; end
                4'd4: begin add_patch(2, V_TOM2); bl = 5'h04; end
                4'd5: begin add_patch(0, V_BASS); add_crash(); bl = 5'h11; end
                4'd7: begin add_patch(1, V_SNARE2); bl = 5'h08; end
                4'd9: begin add_patch(2, V_TOM1); bl = 5'h04; end
                4'd11, 4'd12: begin add_patch(1, V_SNARE); bl = 5'h08; end
                default: bl = 5'h00;
            endcase
        end
        if (dmute_cfg[0]) bl &= ~5'h10;
        if (dmute_cfg[1]) bl &= ~5'h0A;
        if (dmute_cfg[2]) bl &= ~5'h05;
        first = {3'b001, 5'(prev_bits) & (bl ^ 5'h1F)};
        add_write(REG_RHYTHM, first);
        prev_bits = bl;
        add_write(REG_RHYTHM, first | {3'b001, bl});
    endtask

    task automatic predict_tick();
        int         base;
        logic [7:0] cmd;
        logic [5:0] n;
        logic [2:0] oct;
        bit         was_fin;
        if (tick_cnt + 1 < tpr_cfg) begin
            tick_cnt = (tick_cnt + 1) & 9'h1FF;
            return;
        end
        tick_cnt = 0;
        row_writes.delete();
        was_fin = finished;
        if (finished) return;
        if (play_row_idx >= rows_cfg || play_row_idx >= MAX_ROWS_DEF) begin
            finished = 1'b1;
            return;
        end
        base = play_row_idx * ROW_BYTES;
        for (int ch = 0; ch < MEL_CH_DEF; ch++) begin
            cmd = pat_mem[base + ch];
            if (cmd == 0 || cmd > 64 || cmute_cfg[ch]) continue;
            add_write(8'hB0 + 8'(ch), 8'h00);
            if (cmd < 64) begin
                n = 6'(cmd - 1);
                oct = 3'(n / 12);
                add_write(8'hA0 + 8'(ch), fnum_tab[n % 12][7:0]);
                add_write(8'hB0 + 8'(ch), {3'b001, oct + 3'd2, fnum_tab[n % 12][9:8]});
            end
        end
        play_drums(pat_mem[base + DRUM_COL]);
        play_row_idx++;
        if (play_row_idx == rows_cfg) finished = 1'b1;
        foreach (row_writes[k]) begin
            row_writes[k].last = (k == row_writes.size() - 1);
            row_writes[k].ends_song = !was_fin && finished;
            expected_writes.push_back(row_writes[k]);
        end
    endtask

    task automatic queue_request(input logic [1:0] req, input int addr, input int data);
        int row;
        pending_reqs.push_back('{req, 14'(addr), 8'(data)});
        n_pushed++;
        case (req)
            REQ_LOAD: begin
                if (addr < STORE_BYTES) begin
                    pat_mem[addr] = 8'(data);
                    pat_written[addr] = 1'b1;
                    row = addr / ROW_BYTES;
                    if (addr % ROW_BYTES == DRUM_COL) begin
                        if (data != 0) begin
                            if (scan_code == 0 || row >= scan_row) begin
                                scan_row = row;
                                scan_code = data;
                            end
                        end else if (scan_code != 0 && row == scan_row) begin
                            scan_code = 0;
                        end
                    end
                end
            end
            REQ_TICK: predict_tick();
            REQ_RESTART: begin
                play_row_idx = 0;
                tick_cnt = 0;
                finished = 1'b0;
                prev_bits = 0;
            end
            default: ;
        endcase
    endtask

    function automatic int rand_cmd();
        case ($urandom_range(5))
            0: return 0;
            1: return 64;
            2: return $urandom_range(255);
            default: return $urandom_range(1, 63);
        endcase
    endfunction

    function automatic int rand_drum();
        int sel;
        sel = $urandom_range(15);
        case ($urandom_range(3))
            0: return $urandom_range(255);
            1: return sel << 4;
            default: return sel;
        endcase
    endfunction

    // loads any byte that the coming row would read and that is still unwritten
    task automatic send_tick();
        int base;
        if (!finished && tick_cnt + 1 >= tpr_cfg && play_row_idx < rows_cfg) begin
            base = play_row_idx * ROW_BYTES;
            for (int c = 0; c < ROW_BYTES; c++) begin
                if ((c < MEL_CH_DEF || c == DRUM_COL) && !pat_written[base + c]) begin
                    queue_request(REQ_LOAD, base + c, c == DRUM_COL ? rand_drum() : rand_cmd());
                end
            end
        end
        queue_request(REQ_TICK, $urandom_range(16383), $urandom_range(255));
    endtask

    task automatic drain();
        wait (n_taken == n_pushed && expected_writes.size() == 0);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 11'(value);
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_TPR:   tpr_cfg = value;
            CFG_ROWS:  rows_cfg = value;
            CFG_CMUTE: cmute_cfg = value;
            default:   dmute_cfg = value;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic setup(input int tpr, input int rows, input int cm, input int dm);
        drain();
        write_reg(CFG_TPR, tpr);
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_CMUTE, cm);
        write_reg(CFG_DMUTE, dm);
    endtask

    task automatic random_run(input int n_ticks);
        int r, addr;
        for (int i = 0; i < n_ticks; i++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                queue_request(REQ_RESTART, $urandom_range(16383), $urandom_range(255));
            end else if (r < 18) begin
                // rewrite any byte of the song rows, drum bytes included
                addr = $urandom_range(rows_cfg * ROW_BYTES - 1);
                queue_request(REQ_LOAD, addr,
                              addr % ROW_BYTES == DRUM_COL ? rand_drum() : rand_cmd());
            end else if (r < 22) begin
                addr = $urandom_range(MAX_ROWS_DEF - 1) * ROW_BYTES + DRUM_COL;
                queue_request(REQ_LOAD, addr, $urandom_range(3) == 0 ? 0 : rand_drum());
            end else if (r < 24) begin
                queue_request(REQ_LOAD, $urandom_range(16383), $urandom_range(255));
            end else if (r < 25) begin
                queue_request(2'd3, $urandom_range(16383), $urandom_range(255));
            end
            send_tick();
        end
    endtask

    // driver
    always @(negedge aclk) begin
        if (running) begin
            if (!s_valid || s_took) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    s_valid <= 1'b1;
                    s_req_type <= pending_reqs[0].req;
                    s_load_address <= pending_reqs[0].addr;
                    s_load_data <= pending_reqs[0].data;
                    void'(pending_reqs.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        chip_write_t want;
        s_took = aresetn && s_valid && s_ready;
        if (s_took) n_taken++;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("== FAIL ==");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_writes.size() == 0) begin
                errors++;
                $display("%0t unexpected write exp none act %h %h %b %b", $time,
                         m_reg_address, m_reg_value, m_last_of_run, m_song_end);
            end else begin
                want = expected_writes.pop_front();
                if (want != {m_reg_address, m_reg_value, m_last_of_run, m_song_end}) begin
                    errors++;
                    $display("%0t write mismatch exp %h %h %b %b act %h %h %b %b", $time,
                             want.address, want.value, want.last, want.ends_song,
                             m_reg_address, m_reg_value, m_last_of_run, m_song_end);
                end
            end
        end
    end

    initial begin
        play_row_idx = 0; tick_cnt = 0; prev_bits = 0; scan_row = 0; scan_code = 0;
        finished = 1'b0;
        tpr_cfg = 1; rows_cfg = 1; cmute_cfg = 0; dmute_cfg = 0;
        idle_pct = 0; stall_pct = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        running = 1'b1;

        // directed: every command kind, both drum systems, end of song
        setup(1, 4, 0, 0);
        queue_request(REQ_LOAD, 0, 1);
        queue_request(REQ_LOAD, 1, 63);
        queue_request(REQ_LOAD, 2, 64);
        queue_request(REQ_LOAD, 3, 65);
        queue_request(REQ_LOAD, 4, 255);
        queue_request(REQ_LOAD, 5, 0);
        queue_request(REQ_LOAD, DRUM_COL, 5);
        queue_request(REQ_LOAD, 16127, 255);
        queue_request(REQ_LOAD, 16383, 255);
        queue_request(2'd3, 16383, 255);
        for (int i = 0; i < 5; i++) send_tick();
        send_tick();
        // high drum row selects the second drum system, then a zero clears it
        queue_request(REQ_LOAD, 1343 * ROW_BYTES + DRUM_COL, 8'h70);
        queue_request(REQ_RESTART, 0, 0);
        for (int i = 0; i < 3; i++) send_tick();
        queue_request(REQ_LOAD, 1343 * ROW_BYTES + DRUM_COL, 0);
        queue_request(REQ_RESTART, 16383, 255);
        send_tick();

        setup(256, 3, 511, 7);
        random_run(60);
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            case (ph)
                0: setup(1, 1, 0, 0);
                1: setup(1, 1344, $urandom_range(511), 7);
                2: setup(2, $urandom_range(2, 40), 0, $urandom_range(7));
                default: setup($urandom_range(1, 3), $urandom_range(1, 30),
                               $urandom_range(3) == 0 ? $urandom_range(511) : 0,
                               $urandom_range(7));
            endcase
            random_run(15);
        end
        drain();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
